>>> rtl/mpf_pkg.sv
// ----------------------------------------------------------------------------
// mpf_pkg
// shared types and constants of the multichannel pwm fader
// ----------------------------------------------------------------------------
`default_nettype none

package mpf_pkg;

    localparam int DUTY_MAX   = 100;
    localparam int CHANNELS   = 8;
    localparam int FADE_RESET = 200;

    localparam int LEVEL_W = 7;
    localparam int CHAN_W  = 3;
    localparam int MODE_W  = 3;
    localparam int PRE_W   = 16;
    localparam int PINS_W  = 8;

    typedef logic [LEVEL_W-1:0] t_level;
    typedef logic [CHAN_W-1:0]  t_chan;
    typedef logic [MODE_W-1:0]  t_mode_raw;
    typedef logic [PRE_W-1:0]   t_pre;
    typedef logic [PINS_W-1:0]  t_pins;

    typedef enum logic [0:0] {
        ACT_TICK = 1'b0,
        ACT_SET  = 1'b1
    } t_action;

    typedef enum logic [MODE_W-1:0] {
        MODE_IDLE    = 3'd0,
        MODE_ASCEND  = 3'd1,
        MODE_DESCEND = 3'd2,
        MODE_KEEP    = 3'd3,
        MODE_ON      = 3'd4,
        MODE_OFF     = 3'd5
    } t_mode;

endpackage

`default_nettype wire

>>> rtl/mpf_in_if.sv
// ----------------------------------------------------------------------------
// mpf_in_if
// input channel: tick or set command beats
// ----------------------------------------------------------------------------
`default_nettype none

interface mpf_in_if;
    import mpf_pkg::*;

    logic      valid;
    logic      ready;
    logic      action;
    t_chan     channel;
    t_mode_raw new_mode;
    t_level    new_level;

    modport source (output valid, output action, output channel, output new_mode,
                    output new_level, input ready);
    modport sink   (input valid, input action, input channel, input new_mode,
                    input new_level, output ready);
endinterface

`default_nettype wire

>>> rtl/mpf_out_if.sv
// ----------------------------------------------------------------------------
// mpf_out_if
// result channel: pin and fading status beats
// ----------------------------------------------------------------------------
`default_nettype none

interface mpf_out_if;
    import mpf_pkg::*;

    logic  valid;
    logic  ready;
    t_pins pwm_pins;
    t_pins fading_mask;

    modport source (output valid, output pwm_pins, output fading_mask, input ready);
    modport sink   (input valid, input pwm_pins, input fading_mask, output ready);
endinterface

`default_nettype wire

>>> rtl/mpf_cfg_if.sv
// ----------------------------------------------------------------------------
// mpf_cfg_if
// configuration write channel for fade_interval
// ----------------------------------------------------------------------------
`default_nettype none

interface mpf_cfg_if;
    import mpf_pkg::*;

    logic valid;
    logic ready;
    t_pre data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/multichannel_pwm_fader_core.sv
// ----------------------------------------------------------------------------
// multichannel_pwm_fader_core
// eight-channel pwm generator with shared duty counter and timed fading
// ----------------------------------------------------------------------------
// Every input beat is either a pwm tick or a set command for one channel,
// and every input beat yields exactly one result beat carrying the pin
// levels and the ascend/descend mask after that beat. The whole update of
// counter, prescaler and all channels happens in the cycle the beat is
// taken, so the core sustains one beat per clock; the result sits in an
// output register and a new beat is taken whenever that register is empty
// or being drained in the same cycle. fade_interval is written through its
// own channel, which is always ready; a new value is used at the next
// prescaler reload. No clearing pass is needed after reset.
`default_nettype none

module multichannel_pwm_fader_core (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mpf_in_if.sink    i_in,
    mpf_out_if.source o_out,
    mpf_cfg_if.sink   i_cfg
);
    import mpf_pkg::*;

    localparam int CNT_NEXT_W = LEVEL_W + 1;

    // configuration
    t_pre r_fade_interval;

    // shared counters
    t_level r_duty_cnt,  n_duty_cnt;
    t_pre   r_prescale,  n_prescale;

    // per-channel state
    t_mode_raw r_mode  [CHANNELS];
    t_mode_raw n_mode  [CHANNELS];
    t_level    r_level [CHANNELS];
    t_level    n_level [CHANNELS];
    logic      r_pin   [CHANNELS];
    logic      n_pin   [CHANNELS];

    // result register
    logic  r_out_valid;
    t_pins r_pins,   n_pins;
    t_pins r_fading, n_fading;

    // helpers
    logic                  in_beat;
    logic [CNT_NEXT_W-1:0] cnt_inc;
    logic                  cnt_wrap;
    logic                  fade_fire;
    logic                  drives;
    t_level                set_level;

    // one beat per cycle while the result slot is free or draining
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_beat     = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid       = r_out_valid;
    assign o_out.pwm_pins    = r_pins;
    assign o_out.fading_mask = r_fading;

    always_comb begin
        cnt_inc   = CNT_NEXT_W'(r_duty_cnt) + CNT_NEXT_W'(1);
        cnt_wrap  = (cnt_inc >= CNT_NEXT_W'(DUTY_MAX));
        fade_fire = (r_prescale <= t_pre'(1));
        // set levels saturate at full duty
        set_level = (i_in.new_level > t_level'(DUTY_MAX)) ? t_level'(DUTY_MAX)
                                                          : i_in.new_level;

        n_duty_cnt = r_duty_cnt;
        n_prescale = r_prescale;
        if (i_in.action == ACT_TICK) begin
            n_duty_cnt = cnt_wrap ? '0 : cnt_inc[LEVEL_W-1:0];
            n_prescale = fade_fire ? r_fade_interval : r_prescale - t_pre'(1);
        end

        n_pins   = '0;
        n_fading = '0;
        drives   = 1'b0;
        for (int c = 0; c < CHANNELS; c++) begin
            n_mode[c]  = r_mode[c];
            n_level[c] = r_level[c];
            n_pin[c]   = r_pin[c];

            if (i_in.action == ACT_TICK) begin
                drives = (r_mode[c] == MODE_ASCEND) || (r_mode[c] == MODE_DESCEND) ||
                         (r_mode[c] == MODE_KEEP);
                // pin goes high on wrap, then low on compare match
                if (drives && cnt_wrap) begin
                    n_pin[c] = 1'b1;
                end
                if (drives && (n_duty_cnt == r_level[c])) begin
                    n_pin[c] = 1'b0;
                end

                if (fade_fire) begin
                    case (r_mode[c])
                        MODE_ASCEND: begin
                            if (r_level[c] >= t_level'(DUTY_MAX)) begin
                                n_mode[c] = MODE_IDLE;
                            end else begin
                                n_level[c] = r_level[c] + t_level'(1);
                            end
                        end
                        MODE_DESCEND: begin
                            if (r_level[c] == '0) begin
                                n_mode[c] = MODE_IDLE;
                            end else begin
                                n_level[c] = r_level[c] - t_level'(1);
                            end
                        end
                        MODE_ON: begin
                            n_mode[c]  = MODE_IDLE;
                            n_level[c] = t_level'(DUTY_MAX);
                        end
                        MODE_OFF: begin
                            n_mode[c]  = MODE_IDLE;
                            n_level[c] = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end else if (i_in.channel == t_chan'(c)) begin
                // set command: store mode and level only
                n_mode[c]  = i_in.new_mode;
                n_level[c] = set_level;
            end

            n_pins[c]   = n_pin[c];
            n_fading[c] = (n_mode[c] == MODE_ASCEND) || (n_mode[c] == MODE_DESCEND);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade_interval <= t_pre'(FADE_RESET);
        end else if (i_cfg.valid) begin
            r_fade_interval <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty_cnt <= '0;
            r_prescale <= t_pre'(FADE_RESET);
            for (int c = 0; c < CHANNELS; c++) begin
                r_mode[c]  <= MODE_IDLE;
                r_level[c] <= '0;
                r_pin[c]   <= 1'b0;
            end
        end else if (in_beat) begin
            r_duty_cnt <= n_duty_cnt;
            r_prescale <= n_prescale;
            for (int c = 0; c < CHANNELS; c++) begin
                r_mode[c]  <= n_mode[c];
                r_level[c] <= n_level[c];
                r_pin[c]   <= n_pin[c];
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_beat) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_pins   <= n_pins;
            r_fading <= n_fading;
        end
    end

endmodule

`default_nettype wire

>>> tb/sv/tb_multichannel_pwm_fader_core.sv
// ----------------------------------------------------------------------------
// tb_multichannel_pwm_fader_core
// self-checking bench for the multichannel pwm fader core
// ----------------------------------------------------------------------------
// Drives tick and set-command beats in random bursts. The output ready line
// follows a stall pattern that changes over the run. A predictor in the bench
// tracks the duty counter, the fade prescaler and the mode, level and pin of
// every channel. It queues the expected pin and fading status for each input
// beat that is taken. The checker compares every result beat, field by field,
// with the oldest queued status. fade_interval goes through several settings,
// among them zero, one and the largest value. It is written only when no
// result is outstanding.
`default_nettype none

module tb_multichannel_pwm_fader_core;
    import mpf_pkg::*;

    // modes 6 and 7 have no package name; they are stored but act as idle
    localparam t_mode_raw MODE_RSVD6 = 3'd6;
    localparam t_mode_raw MODE_RSVD7 = 3'd7;
    localparam t_level    LEVEL_TOP  = '1;
    localparam t_level    LEVEL_FULL = t_level'(DUTY_MAX);
    localparam int        IDLE_LIMIT = 1000;
    localparam int        PHASE_LEN  = 125;

    typedef struct {
        t_action   action;
        t_chan     channel;
        t_mode_raw new_mode;
        t_level    new_level;
    } t_fader_cmd;

    typedef struct packed {
        t_pins pins;
        t_pins fading;
    } t_pin_status;

    logic i_clk;
    logic i_rst_n;

    mpf_in_if  in_bus ();
    mpf_out_if out_bus ();
    mpf_cfg_if cfg_bus ();

    multichannel_pwm_fader_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .i_cfg   (cfg_bus)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------
    // predictor state, a shadow of the core
    // ------------------------------------------------------------------
    t_pre      step_interval;
    t_pre      fade_count;
    t_level    duty_pos;
    t_mode_raw ch_mode  [CHANNELS];
    t_level    ch_level [CHANNELS];
    logic      ch_pin   [CHANNELS];

    t_pin_status pin_status_q[$];
    int          fail_cnt    = 0;
    int          burst_left  = 0;
    int          idle_cycles = 0;

    function automatic bit mode_drives_pin(t_mode_raw m);
        return m == MODE_ASCEND || m == MODE_DESCEND || m == MODE_KEEP;
    endfunction

    // one fade step over all channels, run at each prescaler reload
    function automatic void fade_advance();
        for (int c = 0; c < CHANNELS; c++) begin
            case (ch_mode[c])
                MODE_ASCEND: begin
                    if (ch_level[c] >= LEVEL_FULL) ch_mode[c] = MODE_IDLE;
                    else ch_level[c] = ch_level[c] + 1'b1;
                end
                MODE_DESCEND: begin
                    if (ch_level[c] == '0) ch_mode[c] = MODE_IDLE;
                    else ch_level[c] = ch_level[c] - 1'b1;
                end
                MODE_ON: begin
                    ch_mode[c]  = MODE_IDLE;
                    ch_level[c] = LEVEL_FULL;
                end
                MODE_OFF: begin
                    ch_mode[c]  = MODE_IDLE;
                    ch_level[c] = '0;
                end
                default: ;
            endcase
        end
    endfunction

    // applies one accepted beat and returns the status the core must report
    function automatic t_pin_status fader_apply(t_fader_cmd cmd);
        t_pin_status st;
        int          nxt;
        if (cmd.action == ACT_TICK) begin
            // counter step and wrap first, then the compare, then the fade
            nxt = int'(duty_pos) + 1;
            if (nxt >= DUTY_MAX) begin
                duty_pos = '0;
                for (int c = 0; c < CHANNELS; c++)
                    if (mode_drives_pin(ch_mode[c])) ch_pin[c] = 1'b1;
            end else begin
                duty_pos = t_level'(nxt);
            end
            for (int c = 0; c < CHANNELS; c++)
                if (mode_drives_pin(ch_mode[c]) && duty_pos == ch_level[c])
                    ch_pin[c] = 1'b0;
            if (fade_count <= 1) begin
                fade_count = step_interval;
                fade_advance();
            end else begin
                fade_count = fade_count - 1'b1;
            end
        end else if (int'(cmd.channel) < CHANNELS) begin
            ch_mode[cmd.channel]  = cmd.new_mode;
            ch_level[cmd.channel] = (cmd.new_level > LEVEL_FULL) ? LEVEL_FULL
                                                                 : cmd.new_level;
        end
        st = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            st.pins[c]   = ch_pin[c];
            st.fading[c] = ch_mode[c] == MODE_ASCEND || ch_mode[c] == MODE_DESCEND;
        end
        return st;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_level pick_level();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return LEVEL_FULL;
            2:       return LEVEL_TOP;
            3:       return LEVEL_FULL - 1'b1;
            default: return t_level'($urandom_range(0, 127));
        endcase
    endfunction

    // tick beats carry random don't-care fields
    function automatic t_fader_cmd tick_cmd();
        t_fader_cmd cmd;
        cmd.action    = ACT_TICK;
        cmd.channel   = t_chan'($urandom_range(0, 7));
        cmd.new_mode  = t_mode_raw'($urandom_range(0, 7));
        cmd.new_level = t_level'($urandom_range(0, 127));
        return cmd;
    endfunction

    function automatic t_fader_cmd set_cmd(t_chan ch, t_mode_raw m, t_level lvl);
        t_fader_cmd cmd;
        cmd.action    = ACT_SET;
        cmd.channel   = ch;
        cmd.new_mode  = m;
        cmd.new_level = lvl;
        return cmd;
    endfunction

    // sends one beat; entered and left at a falling edge, valid stays high
    // between beats of a burst and drops only for a gap
    task automatic send_beat(input t_fader_cmd cmd);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                in_bus.valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_bus.valid     = 1'b1;
        in_bus.action    = cmd.action;
        in_bus.channel   = cmd.channel;
        in_bus.new_mode  = cmd.new_mode;
        in_bus.new_level = cmd.new_level;
        do @(posedge i_clk); while (!in_bus.ready);
        pin_status_q.push_back(fader_apply(cmd));
        @(negedge i_clk);
    endtask

    // stops the sender and waits until every expected beat has come back
    task automatic drain_results();
        in_bus.valid = 1'b0;
        burst_left   = 0;
        while (pin_status_q.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    // only called with the core idle
    task automatic write_fade_interval(input t_pre value);
        cfg_bus.valid = 1'b1;
        cfg_bus.data  = value;
        do @(posedge i_clk); while (!cfg_bus.ready);
        step_interval = value;
        @(negedge i_clk);
        cfg_bus.valid = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_reset_state();
        repeat (2) send_beat(tick_cmd());
        drain_results();
    endtask

    // every mode, level extremes and saturation, then fast fades
    task automatic test_set_commands();
        write_fade_interval(16'd1);
        send_beat(set_cmd(3'd0, MODE_KEEP, '0));          // high and low on one tick
        send_beat(set_cmd(3'd7, MODE_KEEP, LEVEL_TOP));   // saturates, stays high
        send_beat(set_cmd(3'd1, MODE_ASCEND, LEVEL_FULL - 1'b1));
        send_beat(set_cmd(3'd2, MODE_DESCEND, 7'd1));
        send_beat(set_cmd(3'd3, MODE_ON, '0));
        send_beat(set_cmd(3'd4, MODE_OFF, LEVEL_TOP));
        send_beat(set_cmd(3'd5, MODE_RSVD6, 7'd64));
        send_beat(set_cmd(3'd6, MODE_RSVD7, LEVEL_FULL));
        send_beat(set_cmd(3'd5, MODE_IDLE, 7'd63));
        repeat (5) send_beat(tick_cmd());
        drain_results();
    endtask

    // zero interval runs the fade step on every tick
    task automatic test_zero_interval();
        write_fade_interval(16'd0);
        send_beat(set_cmd(3'd1, MODE_ASCEND, LEVEL_FULL - 7'd2));
        repeat (4) send_beat(tick_cmd());
        drain_results();
    endtask

    task automatic test_random_phases();
        t_pre iv;
        int   tick_pct;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0:       iv = 16'd1;
                1:       iv = 16'hFFFF;
                2:       iv = 16'd0;
                3:       iv = t_pre'($urandom_range(2, 12));
                4:       iv = t_pre'($urandom_range(13, 60));
                default: iv = t_pre'(FADE_RESET);
            endcase
            write_fade_interval(iv);
            tick_pct = (ph == 1) ? 70 : 85;
            for (int n = 0; n < PHASE_LEN; n++) begin
                if ($urandom_range(0, 99) < tick_pct)
                    send_beat(tick_cmd());
                else
                    send_beat(set_cmd(t_chan'($urandom_range(0, 7)),
                                      t_mode_raw'($urandom_range(0, 7)),
                                      pick_level()));
            end
            drain_results();
        end
    endtask

    // ------------------------------------------------------------------
    // result side: ready stalls on a 16-bit pattern that is redrawn each
    // time it runs out; a quarter of the patterns never stall
    // ------------------------------------------------------------------
    logic [15:0] stall_pat = '1;
    logic [3:0]  stall_idx = '0;

    always @(negedge i_clk) begin
        if (stall_idx == '0)
            stall_pat = ($urandom_range(0, 3) == 0) ? '1 : 16'($urandom | $urandom);
        out_bus.ready = stall_pat[stall_idx];
        stall_idx     = stall_idx + 1'b1;
    end

    // compare each result beat with the oldest expected status
    always @(posedge i_clk) begin : result_check
        t_pin_status want;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (pin_status_q.size() == 0) begin
                $error("result beat with nothing expected: pwm_pins %h fading_mask %h",
                       out_bus.pwm_pins, out_bus.fading_mask);
                fail_cnt++;
            end else begin
                want = pin_status_q.pop_front();
                if (out_bus.pwm_pins !== want.pins) begin
                    $error("pwm_pins expected %h actual %h", want.pins, out_bus.pwm_pins);
                    fail_cnt++;
                end
                if (out_bus.fading_mask !== want.fading) begin
                    $error("fading_mask expected %h actual %h",
                           want.fading, out_bus.fading_mask);
                    fail_cnt++;
                end
            end
        end
    end

    // watchdog: too long without any beat on any channel ends the run
    always @(posedge i_clk) begin
        if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
            (cfg_bus.valid && cfg_bus.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("multichannel_pwm_fader_core: mismatch");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n          = 1'b0;
        in_bus.valid     = 1'b0;
        in_bus.action    = ACT_TICK;
        in_bus.channel   = '0;
        in_bus.new_mode  = MODE_IDLE;
        in_bus.new_level = '0;
        cfg_bus.valid    = 1'b0;
        cfg_bus.data     = '0;
        out_bus.ready    = 1'b1;

        step_interval = t_pre'(FADE_RESET);
        fade_count    = t_pre'(FADE_RESET);
        duty_pos      = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            ch_mode[c]  = MODE_IDLE;
            ch_level[c] = '0;
            ch_pin[c]   = 1'b0;
        end

        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_reset_state();
        test_set_commands();
        test_zero_interval();
        test_random_phases();

        repeat (4) @(negedge i_clk);
        if (fail_cnt == 0 && pin_status_q.size() == 0)
            $display("multichannel_pwm_fader_core: match");
        else
            $display("multichannel_pwm_fader_core: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
